// ===== rtl/core/pli_pkg.sv =====
// Package for the piecewise linear interpolator: sizes, item codes, status codes,
// state types, the queue entry type and a saturation helper. It has no dependencies.
package pli_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxW = $clog2(MaxPoints);
    localparam int CntW = $clog2(MaxPoints + 1);

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_CLAMP  = 2'd2,
        MODE_WRAP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_INCR = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // One transaction as it sits in the queue between front and back.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
    } item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_APP_RD,
        S_APP_WAIT,
        S_APP_DIV,
        S_APP_DIVRUN,
        S_APP_WR,
        S_Q_RDLAST,
        S_Q_WAITLAST,
        S_Q_WRAPDIV,
        S_Q_WRAPRUN,
        S_Q_WRAPMUL,
        S_Q_WRAPSUB,
        S_Q_RDFIRST,
        S_Q_WAITFIRST,
        S_Q_BOUNDS,
        S_Q_SRCH_RD,
        S_Q_SRCH_WAIT,
        S_Q_SEG_RD,
        S_Q_SEG_WAIT,
        S_Q_MUL,
        S_Q_SCALE,
        S_Q_SUM,
        S_RESULT
    } back_state_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/pli_front.sv =====
// Front end of the interpolator: takes input transactions and holds them in a
// two-entry queue until the back end picks them up. Uses pli_pkg.
module pli_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,   // mode[1:0], x_value[33:2], y_value[65:34], zero pad
    output logic          q_valid,
    input  logic          q_take,
    output pli_pkg::item_t q_item
);
    import pli_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push, pop;

    assign s_tready = (fill_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_take && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= '{mode: s_tdata[1:0], x_value: s_tdata[33:2],
                                      y_value: s_tdata[65:34]};
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/core/pli_divider.sv =====
// Restoring signed divider, one quotient bit per cycle, 64-bit dividend by
// 33-bit divisor, quotient truncated toward zero. Uses pli_pkg.
module pli_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic signed [32:0] divisor,
    output logic               done,
    output logic signed [63:0] quotient,
    output logic signed [32:0] remainder
);
    import pli_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] den_reg;
    logic        qneg_reg, rneg_reg, busy_reg;
    logic [6:0]  cnt_reg;
    logic [33:0] trial;
    logic [63:0] dvd_mag;
    logic [32:0] dvs_mag;

    assign dvd_mag = dividend[63] ? 64'(-dividend) : 64'(dividend);
    assign dvs_mag = divisor[32] ? 33'(-divisor) : 33'(divisor);

    // One shift-subtract step
    always_comb begin
        trial    = {rem_reg[32:0], quo_reg[63]};
        quo_next = {quo_reg[62:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, den_reg}) begin
            rem_next    = trial - {1'b0, den_reg};
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg  <= dvd_mag;
            rem_reg  <= '0;
            den_reg  <= dvs_mag;
            qneg_reg <= dividend[63] ^ divisor[32];
            rneg_reg <= dividend[63];
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = qneg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    assign remainder = rneg_reg ? -$signed(rem_reg[32:0]) : $signed(rem_reg[32:0]);

endmodule

// ===== rtl/core/pli_back.sv =====
// Back end of the interpolator: owns the breakpoint tables and the point count,
// and runs append, clear and query sequences. Uses pli_pkg and pli_divider.
module pli_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_take,
    input  pli_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [79:0]    m_tdata   // result_value[31:0], status[33:32],
                                     // point_total[40:34], x_last[72:41], zero pad
);
    import pli_pkg::*;

    back_state_t        state_reg, state_next;
    item_t              item_reg;
    logic [CntW-1:0]    count_reg;
    logic signed [31:0] xlast_reg;

    // Tables: x and y and slope, one memory each, registered read
    logic signed [31:0] xmem [MaxPoints];
    logic signed [31:0] ymem [MaxPoints];
    logic signed [31:0] smem [MaxPoints];
    logic [IdxW-1:0]    rd_addr;
    logic signed [31:0] xrd_reg, yrd_reg, srd_reg;
    logic               wr_pt, wr_slope;
    logic [IdxW-1:0]    wr_addr;

    // Working registers
    logic signed [32:0] wx_reg;     // working x (after wrap)
    logic signed [31:0] y0_reg;     // y of previous point on append
    logic [IdxW-1:0]    lo_reg, hi_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] scaled_reg, res_reg;
    logic [1:0]         stat_reg;
    logic signed [63:0] tq_reg;

    // Divider hookup
    logic               div_start, div_done;
    logic signed [63:0] div_dvd, div_quo;
    logic signed [32:0] div_dvs, div_rem;

    logic [IdxW-1:0]    mid;
    logic [IdxW-1:0]    last_idx;
    logic signed [63:0] dy64;
    logic               out_full_reg;

    assign last_idx = IdxW'(count_reg - CntW'(1));
    assign mid      = IdxW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign dy64     = 64'(signed'({item_reg.y_value[31], item_reg.y_value}) - y0_reg) <<< 16;

    pli_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer: next state and strobes
    always_comb begin
        state_next = state_reg;
        q_take     = 1'b0;
        div_start  = 1'b0;
        div_dvd    = dy64;
        div_dvs    = 33'(item_reg.x_value) - 33'(xrd_reg);
        rd_addr    = last_idx;
        wr_pt      = 1'b0;
        wr_slope   = 1'b0;
        wr_addr    = IdxW'(count_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && !out_full_reg) begin
                    q_take     = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (item_reg.mode)
                    MODE_CLEAR:  state_next = S_RESULT;
                    MODE_APPEND: begin
                        if (count_reg >= CntW'(MaxPoints)) state_next = S_RESULT;
                        else if (count_reg == '0) state_next = S_APP_WR;
                        else if (item_reg.x_value <= xlast_reg) state_next = S_RESULT;
                        else state_next = S_APP_RD;
                    end
                    default: begin
                        if (count_reg == '0) state_next = S_RESULT;
                        else state_next = S_Q_RDLAST;
                    end
                endcase
            end
            S_APP_RD:   state_next = S_APP_WAIT;
            S_APP_WAIT: state_next = S_APP_DIV;
            S_APP_DIV: begin
                div_start  = 1'b1;
                state_next = S_APP_DIVRUN;
            end
            S_APP_DIVRUN: begin
                if (div_done) begin
                    wr_slope   = 1'b1;
                    wr_addr    = last_idx;
                    state_next = S_APP_WR;
                end
            end
            S_APP_WR: begin
                wr_pt      = 1'b1;
                state_next = S_RESULT;
            end
            S_Q_RDLAST:   state_next = S_Q_WAITLAST;
            S_Q_WAITLAST: begin
                if (item_reg.mode == MODE_WRAP && xlast_reg != '0 &&
                    (item_reg.x_value < 0 || item_reg.x_value > xlast_reg))
                    state_next = S_Q_WRAPDIV;
                else
                    state_next = S_Q_RDFIRST;
            end
            S_Q_WRAPDIV: begin
                div_start  = 1'b1;
                div_dvd    = 64'(item_reg.x_value);
                div_dvs    = 33'(xlast_reg);
                state_next = S_Q_WRAPRUN;
            end
            S_Q_WRAPRUN: begin
                div_dvd = 64'(item_reg.x_value);
                div_dvs = 33'(xlast_reg);
                if (div_done) state_next = S_Q_RDFIRST;
            end
            S_Q_WRAPMUL: state_next = S_Q_RDFIRST;
            S_Q_WRAPSUB: state_next = S_Q_RDFIRST;
            S_Q_RDFIRST: begin
                rd_addr    = '0;
                state_next = S_Q_WAITFIRST;
            end
            // keep the first point on the read port through the bounds check
            S_Q_WAITFIRST: begin
                rd_addr    = '0;
                state_next = S_Q_BOUNDS;
            end
            S_Q_BOUNDS: begin
                if (wx_reg <= 33'(xrd_reg) || wx_reg >= 33'(xlast_reg))
                    state_next = S_Q_SEG_RD;
                else if (hi_reg - lo_reg > IdxW'(1))
                    state_next = S_Q_SRCH_RD;
                else
                    state_next = S_Q_SEG_RD;
            end
            S_Q_SRCH_RD: begin
                rd_addr    = mid;
                state_next = S_Q_SRCH_WAIT;
            end
            S_Q_SRCH_WAIT: begin
                if (hi_reg - lo_reg > IdxW'(1)) state_next = S_Q_SRCH_RD;
                else state_next = S_Q_SEG_RD;
            end
            // segment point stays on the read port until the sum
            S_Q_SEG_RD: begin
                rd_addr    = lo_reg;
                state_next = S_Q_SEG_WAIT;
            end
            S_Q_SEG_WAIT: begin
                rd_addr    = lo_reg;
                state_next = S_Q_MUL;
            end
            S_Q_MUL: begin
                rd_addr    = lo_reg;
                state_next = S_Q_SCALE;
            end
            S_Q_SCALE: begin
                rd_addr    = lo_reg;
                state_next = S_Q_SUM;
            end
            S_Q_SUM:      state_next = S_RESULT;
            S_RESULT:     state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // Table memories
    always_ff @(posedge aclk) begin
        if (wr_pt) begin
            xmem[wr_addr] <= item_reg.x_value;
            ymem[wr_addr] <= item_reg.y_value;
        end
        if (wr_slope) smem[wr_addr] <= sat32(div_quo);
        xrd_reg <= xmem[rd_addr];
        yrd_reg <= ymem[rd_addr];
        srd_reg <= smem[rd_addr];
    end

    // Control state: point count and last x
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            xlast_reg <= '0;
        end else if (state_reg == S_DISPATCH && item_reg.mode == MODE_CLEAR) begin
            count_reg <= '0;
            xlast_reg <= '0;
        end else if (wr_pt) begin
            count_reg <= count_reg + CntW'(1);
            xlast_reg <= item_reg.x_value;
        end
    end

    // Datapath work registers
    always_ff @(posedge aclk) begin
        if (q_take) item_reg <= q_item;
        unique case (state_reg)
            S_DISPATCH: begin
                res_reg  <= '0;
                stat_reg <= ST_OK;
                if (item_reg.mode == MODE_APPEND) begin
                    if (count_reg >= CntW'(MaxPoints)) stat_reg <= ST_FULL;
                    else if (count_reg != '0 && item_reg.x_value <= xlast_reg)
                        stat_reg <= ST_NOT_INCR;
                end else if (item_reg.mode != MODE_CLEAR && count_reg == '0) begin
                    stat_reg <= ST_EMPTY;
                end
                wx_reg <= 33'(item_reg.x_value);
            end
            S_APP_WAIT: y0_reg <= yrd_reg;
            S_Q_WRAPRUN: if (div_done) wx_reg <= div_rem;
            S_Q_WAITFIRST: begin
                lo_reg <= '0;
                hi_reg <= last_idx;
            end
            S_Q_BOUNDS: begin
                if (wx_reg <= 33'(xrd_reg)) begin
                    lo_reg <= '0;
                    scaled_reg <= '0;
                end else if (wx_reg >= 33'(xlast_reg)) begin
                    lo_reg <= last_idx;
                end
            end
            S_Q_SRCH_WAIT: begin
                if (33'(xrd_reg) < wx_reg) lo_reg <= mid;
                else hi_reg <= mid;
            end
            S_Q_MUL: begin
                if (wx_reg <= 33'(xrd_reg) || wx_reg >= 33'(xlast_reg)) prod_reg <= '0;
                else prod_reg <= 64'(srd_reg) * 64'(wx_reg - 33'(xrd_reg));
            end
            S_Q_SCALE: scaled_reg <= sat32(prod_reg >>> 16);
            S_Q_SUM: res_reg <= sat32(64'(yrd_reg) + 64'(scaled_reg));
            default: ;
        endcase
    end

    // Output register, freed when the downstream takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_full_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) out_full_reg <= 1'b0;
            if (state_reg == S_RESULT) out_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RESULT) begin
            m_tdata <= {7'd0, xlast_reg, 7'(count_reg), stat_reg, res_reg};
        end
    end

    assign m_tvalid = out_full_reg;

endmodule

// ===== rtl/core/piecewise_linear_interpolator.sv =====
// Piecewise linear interpolator top level: joins the queueing front end and
// the table back end. Uses pli_pkg, pli_front and pli_back.
//
// Each transaction runs alone in the back end. An append runs the 64-step
// shift-subtract divider to set the slope, a query inside the table's x range
// finds its segment by binary search over the points, and a wrapped query that
// reduces x runs the same divider before the search. Two input transactions
// can queue in front while one runs, and one finished result waits in the
// output register. Tables hold 64 points and are not cleared; only written
// points are ever read.
module piecewise_linear_interpolator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // mode[1:0], x_value[33:2], y_value[65:34], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // result_value[31:0], status[33:32],
                                   // point_total[40:34], x_last[72:41], zero pad
);
    import pli_pkg::*;

    logic  q_valid, q_take;
    item_t q_item;

    pli_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item)
    );

    pli_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
